>>> sv/tree_lca_binary_lifting_assert.svh
// ----------------------------------------------------------------------------
// tree lca assertion macros
// Shared concurrent assertion forms for the lowest common ancestor engine.
// ----------------------------------------------------------------------------
`ifndef TREE_LCA_BINARY_LIFTING_ASSERT_SVH
`define TREE_LCA_BINARY_LIFTING_ASSERT_SVH

// antecedent in this cycle, consequent from the next cycle on
`define TLCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent and consequent in the same cycle
`define TLCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/tlca_pkg.sv
// ----------------------------------------------------------------------------
// tlca_pkg
// Types and constants of the binary lifting lowest common ancestor engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlca_pkg;

  localparam int unsigned NODES_DEF  = 1024;
  localparam int unsigned LEVELS_DEF = 10;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned NODE_W  = 10;
  localparam int unsigned DEPTH_W = 10;
  localparam int unsigned DIST_W  = 11;
  localparam int unsigned CFG_W   = 11;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(1024);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [NODE_W-1:0]  first_node;
    logic [NODE_W-1:0]  second_node;
    logic [DEPTH_W-1:0] node_depth;
    logic               is_root;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] common_ancestor;
    logic [DIST_W-1:0] path_distance;
  } result_t;

endpackage

>>> sv/tlca_if.sv
// ----------------------------------------------------------------------------
// tlca_if
// Valid/ready channels for requests and results of the lca engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlca_req_if import tlca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [NODE_W-1:0]  first_node;
  logic [NODE_W-1:0]  second_node;
  logic [DEPTH_W-1:0] node_depth;
  logic               is_root;

  modport source (
    output valid, mode, first_node, second_node, node_depth, is_root,
    input  ready
  );
  modport sink (
    input  valid, mode, first_node, second_node, node_depth, is_root,
    output ready
  );
endinterface

interface tlca_res_if import tlca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] common_ancestor;
  logic [DIST_W-1:0] path_distance;

  modport source (
    output valid, common_ancestor, path_distance,
    input  ready
  );
  modport sink (
    input  valid, common_ancestor, path_distance,
    output ready
  );
endinterface

>>> sv/tlca_ram.sv
// ----------------------------------------------------------------------------
// tlca_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlca_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned ABW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [ABW-1:0]   waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [ABW-1:0]   raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tlca_alu.sv
// ----------------------------------------------------------------------------
// tlca_alu
// Shared add/subtract unit with borrow flag, used for index reduction,
// depth compare and path distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlca_alu #(
  parameter int unsigned W = 11
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o,
  output logic         borrow_o
);

  logic [W:0] sum;

  assign sum      = sub_i ? ({1'b0, a_i} - {1'b0, b_i}) : ({1'b0, a_i} + {1'b0, b_i});
  assign res_o    = sum[W-1:0];
  assign borrow_o = sub_i & sum[W];

endmodule

>>> sv/tlca_core.sv
// ----------------------------------------------------------------------------
// tlca_core
// Sequencer and datapath: depth and ancestor memories, one shared alu,
// load, build and query walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlca_core import tlca_pkg::*; #(
  parameter int unsigned NODES  = NODES_DEF,
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] node_count_i,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_data_o
);

  localparam int unsigned NW  = $clog2(NODES);
  localparam int unsigned AW  = $clog2(NODES + 1);
  localparam int unsigned RW  = (AW > NODE_W) ? AW : NODE_W;
  localparam int unsigned UW  = (RW > DIST_W) ? RW : DIST_W;
  localparam int unsigned LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CW  = AW;
  localparam int unsigned CMW = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned TD  = NODES * LEVELS;
  localparam int unsigned TAW = (TD > 1) ? $clog2(TD) : 1;

  localparam logic [RW-1:0] NONE_R  = RW'(NODES);
  localparam logic [AW-1:0] NONE_A  = AW'(NODES);
  localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

  typedef enum logic [23:0] {
    ST_IDLE    = 24'h000001,
    ST_RED_A   = 24'h000002,
    ST_RED_B   = 24'h000004,
    ST_LOAD    = 24'h000008,
    ST_DEP_A   = 24'h000010,
    ST_DEP_B   = 24'h000020,
    ST_DEP_CMP = 24'h000040,
    ST_DEP_SWP = 24'h000080,
    ST_LIFT    = 24'h000100,
    ST_LIFT_W  = 24'h000200,
    ST_EQ      = 24'h000400,
    ST_CLB_A   = 24'h000800,
    ST_CLB_B   = 24'h001000,
    ST_CLB_CMP = 24'h002000,
    ST_FIN     = 24'h004000,
    ST_FIN_W   = 24'h008000,
    ST_CDEP    = 24'h010000,
    ST_CDEP_W  = 24'h020000,
    ST_DIST_B  = 24'h040000,
    ST_DIST_C  = 24'h080000,
    ST_OUT     = 24'h100000,
    ST_BLD_RD  = 24'h200000,
    ST_BLD_X   = 24'h400000,
    ST_BLD_Y   = 24'h800000
  } state_e;

  state_e             state_q, state_d;
  logic [RW-1:0]      a_q, a_d, b_q, b_d;
  logic [AW-1:0]      x_q, x_d;
  logic [DEPTH_W-1:0] da_q, da_d, db_q, db_d, delta_q, delta_d;
  logic [DIST_W-1:0]  dist_q, dist_d;
  logic [LW-1:0]      lvl_q, lvl_d;
  logic [CW-1:0]      j_q, j_d, cnt_q, cnt_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               root_q, root_d;

  logic               dep_we, dep_re;
  logic [NW-1:0]      dep_waddr, dep_raddr;
  logic [DEPTH_W-1:0] dep_rdata;

  logic               anc_we, anc_re;
  logic [NW-1:0]      anc_wnode, anc_rnode;
  logic [LW-1:0]      anc_wlvl, anc_rlvl;
  logic [AW-1:0]      anc_wdata, anc_rdata, anc_y;

  logic [UW-1:0]      alu_a, alu_b, alu_res;
  logic               alu_sub, alu_borrow;

  logic               a_none, b_none;
  logic [LW-1:0]      lvl_dec, lvl_inc;
  logic [CW-1:0]      j_inc;
  logic [CMW-1:0]     cnt_full;

  function automatic logic [TAW-1:0] anc_addr(input logic [NW-1:0] node,
                                             input logic [LW-1:0] lvl);
    anc_addr = TAW'(node) * TAW'(LEVELS) + TAW'(lvl);
  endfunction

  assign a_none   = (a_q == NONE_R);
  assign b_none   = (b_q == NONE_R);
  assign lvl_dec  = LW'(lvl_q - 1'b1);
  assign lvl_inc  = LW'(lvl_q + 1'b1);
  assign j_inc    = CW'(j_q + 1'b1);
  assign cnt_full = (CMW'(node_count_i) > CMW'(NODES)) ? CMW'(NODES) : CMW'(node_count_i);
  assign anc_y    = b_none ? NONE_A : anc_rdata;

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    x_d     = x_q;
    da_d    = da_q;
    db_d    = db_q;
    delta_d = delta_q;
    dist_d  = dist_q;
    lvl_d   = lvl_q;
    j_d     = j_q;
    cnt_d   = cnt_q;
    mode_d  = mode_q;
    depth_d = depth_q;
    root_d  = root_q;

    dep_we    = 1'b0;
    dep_waddr = a_q[NW-1:0];
    dep_re    = 1'b0;
    dep_raddr = a_q[NW-1:0];
    anc_we    = 1'b0;
    anc_wnode = a_q[NW-1:0];
    anc_wlvl  = '0;
    anc_wdata = NONE_A;
    anc_re    = 1'b0;
    anc_rnode = a_q[NW-1:0];
    anc_rlvl  = lvl_q;

    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;

    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          case (req_i.mode)
            MODE_LOAD, MODE_QUERY: begin
              mode_d  = req_i.mode;
              a_d     = RW'(req_i.first_node);
              b_d     = RW'(req_i.second_node);
              depth_d = req_i.node_depth;
              root_d  = req_i.is_root;
              state_d = ST_RED_A;
            end
            MODE_BUILD: begin
              cnt_d = CW'(cnt_full);
              j_d   = '0;
              lvl_d = LW'(1);
              if (LEVELS > 1 && cnt_full != '0) begin
                state_d = ST_BLD_RD;
              end
            end
            default: begin
              // unused mode: request is dropped
            end
          endcase
        end
      end

      // fold indices into range one subtraction a cycle
      ST_RED_A: begin
        alu_a = UW'(a_q);
        alu_b = UW'(NODES);
        if (!alu_borrow) begin
          a_d = RW'(alu_res);
        end else begin
          state_d = ST_RED_B;
        end
      end
      ST_RED_B: begin
        alu_a = UW'(b_q);
        alu_b = UW'(NODES);
        if (!alu_borrow) begin
          b_d = RW'(alu_res);
        end else if (mode_q == MODE_LOAD) begin
          state_d = ST_LOAD;
        end else begin
          state_d = ST_DEP_A;
        end
      end

      ST_LOAD: begin
        dep_we    = 1'b1;
        anc_we    = 1'b1;
        anc_wdata = root_q ? NONE_A : AW'(b_q);
        state_d   = ST_IDLE;
      end

      ST_DEP_A: begin
        dep_re  = 1'b1;
        state_d = ST_DEP_B;
      end
      ST_DEP_B: begin
        da_d      = dep_rdata;
        dep_re    = 1'b1;
        dep_raddr = b_q[NW-1:0];
        state_d   = ST_DEP_CMP;
      end
      ST_DEP_CMP: begin
        db_d  = dep_rdata;
        alu_a = UW'(dep_rdata);
        alu_b = UW'(da_q);
        lvl_d = '0;
        if (alu_borrow) begin
          state_d = ST_DEP_SWP;
        end else begin
          delta_d = alu_res[DEPTH_W-1:0];
          state_d = ST_LIFT;
        end
      end
      // first node is deeper: swap so the second is the one lifted
      ST_DEP_SWP: begin
        alu_a   = UW'(da_q);
        alu_b   = UW'(db_q);
        delta_d = alu_res[DEPTH_W-1:0];
        a_d     = b_q;
        b_d     = a_q;
        state_d = ST_LIFT;
      end

      ST_LIFT: begin
        if (delta_q[0] && !b_none) begin
          anc_re    = 1'b1;
          anc_rnode = b_q[NW-1:0];
          state_d   = ST_LIFT_W;
        end else begin
          delta_d = delta_q >> 1;
          if (lvl_q == LVL_TOP) begin
            state_d = ST_EQ;
          end else begin
            lvl_d = lvl_inc;
          end
        end
      end
      ST_LIFT_W: begin
        b_d     = RW'(anc_rdata);
        delta_d = delta_q >> 1;
        if (lvl_q == LVL_TOP) begin
          state_d = ST_EQ;
        end else begin
          lvl_d   = lvl_inc;
          state_d = ST_LIFT;
        end
      end

      ST_EQ: begin
        if (a_q == b_q) begin
          state_d = ST_CDEP;
        end else begin
          lvl_d   = LVL_TOP;
          state_d = ST_CLB_A;
        end
      end

      // climb both nodes while their ancestors differ, top level first
      ST_CLB_A: begin
        anc_re  = !a_none;
        state_d = ST_CLB_B;
      end
      ST_CLB_B: begin
        x_d       = a_none ? NONE_A : anc_rdata;
        anc_re    = !b_none;
        anc_rnode = b_q[NW-1:0];
        state_d   = ST_CLB_CMP;
      end
      ST_CLB_CMP: begin
        if (x_q != anc_y) begin
          a_d = RW'(x_q);
          b_d = RW'(anc_y);
        end
        if (lvl_q == '0) begin
          state_d = ST_FIN;
        end else begin
          lvl_d   = lvl_dec;
          state_d = ST_CLB_A;
        end
      end

      ST_FIN: begin
        if (a_none) begin
          a_d     = '0;
          dist_d  = '0;
          state_d = ST_OUT;
        end else begin
          anc_re   = 1'b1;
          anc_rlvl = '0;
          state_d  = ST_FIN_W;
        end
      end
      ST_FIN_W: begin
        if (anc_rdata == NONE_A) begin
          a_d     = '0;
          dist_d  = '0;
          state_d = ST_OUT;
        end else begin
          a_d     = RW'(anc_rdata);
          state_d = ST_CDEP;
        end
      end

      // distance: clamped depth differences to the ancestor, then summed
      ST_CDEP: begin
        dep_re  = 1'b1;
        state_d = ST_CDEP_W;
      end
      ST_CDEP_W: begin
        delta_d = dep_rdata;
        alu_a   = UW'(da_q);
        alu_b   = UW'(dep_rdata);
        dist_d  = alu_borrow ? '0 : DIST_W'(alu_res);
        state_d = ST_DIST_B;
      end
      ST_DIST_B: begin
        alu_a   = UW'(db_q);
        alu_b   = UW'(delta_q);
        delta_d = alu_borrow ? '0 : alu_res[DEPTH_W-1:0];
        state_d = ST_DIST_C;
      end
      ST_DIST_C: begin
        alu_sub = 1'b0;
        alu_a   = UW'(dist_q);
        alu_b   = UW'(delta_q);
        dist_d  = DIST_W'(alu_res);
        state_d = ST_OUT;
      end

      ST_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      // build: entry (j, lvl) = up(up(j, lvl-1), lvl-1)
      ST_BLD_RD: begin
        anc_re    = 1'b1;
        anc_rnode = j_q[NW-1:0];
        anc_rlvl  = lvl_dec;
        state_d   = ST_BLD_X;
      end
      ST_BLD_X, ST_BLD_Y: begin
        if (state_q == ST_BLD_X && anc_rdata != NONE_A) begin
          anc_re    = 1'b1;
          anc_rnode = anc_rdata[NW-1:0];
          anc_rlvl  = lvl_dec;
          state_d   = ST_BLD_Y;
        end else begin
          anc_we    = 1'b1;
          anc_wnode = j_q[NW-1:0];
          anc_wlvl  = lvl_q;
          anc_wdata = anc_rdata;
          state_d   = ST_BLD_RD;
          if (j_inc == cnt_q) begin
            j_d = '0;
            if (lvl_q == LVL_TOP) begin
              state_d = ST_IDLE;
            end else begin
              lvl_d = lvl_inc;
            end
          end else begin
            j_d = j_inc;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lvl_q   <= '0;
      j_q     <= '0;
      cnt_q   <= '0;
      mode_q  <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      j_q     <= j_d;
      cnt_q   <= cnt_d;
      mode_q  <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    x_q     <= x_d;
    da_q    <= da_d;
    db_q    <= db_d;
    delta_q <= delta_d;
    dist_q  <= dist_d;
    depth_q <= depth_d;
    root_q  <= root_d;
  end

  assign req_ready_o                = (state_q == ST_IDLE);
  assign res_data_o.common_ancestor = a_q[NODE_W-1:0];
  assign res_data_o.path_distance   = dist_q;

  tlca_alu #(
    .W (UW)
  ) u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .sub_i    (alu_sub),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  tlca_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (NODES)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (depth_q),
    .re_i    (dep_re),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  tlca_ram #(
    .WIDTH (AW),
    .DEPTH (TD)
  ) u_anc_ram (
    .clk_i   (clk_i),
    .we_i    (anc_we),
    .waddr_i (anc_addr(anc_wnode, anc_wlvl)),
    .wdata_i (anc_wdata),
    .re_i    (anc_re),
    .raddr_i (anc_addr(anc_rnode, anc_rlvl)),
    .rdata_o (anc_rdata)
  );

endmodule

>>> sv/tree_lca_binary_lifting.sv
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting
// Binary lifting lowest common ancestor engine over a rooted tree of up to
// NODES nodes with LEVELS ancestor levels. A load request writes one node's
// depth and parent (or a root mark); a build request fills levels 1 to
// LEVELS-1 of the ancestor memory for the first node_count nodes,
// (LEVELS-1) * node_count entries; a query request returns the lowest
// common ancestor and the path length. The ancestor memory has one read
// port, which serves the lift and the climb in turn. A node index at or
// above NODES is folded into range by subtracting NODES. Both memories
// come up unwritten and need no clearing pass. The engine takes one
// request at a time and drops ready while busy; a finished result waits
// in an output register, so the next request is taken while it is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tree_lca_binary_lifting import tlca_pkg::*; #(
  parameter int unsigned NODES  = NODES_DEF,
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tlca_req_if.sink         req_i,
  tlca_res_if.source       res_o,
  input  logic             node_count_we_i,
  input  logic [CFG_W-1:0] node_count_i
);

  logic [CFG_W-1:0] node_count_q;
  req_t             core_req;
  logic             core_ready;
  logic             core_res_valid;
  logic             core_res_ready;
  result_t          core_res;
  logic             out_valid_q;
  result_t          out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (node_count_we_i) begin
      node_count_q <= node_count_i;
    end
  end

  assign core_req.mode        = req_i.mode;
  assign core_req.first_node  = req_i.first_node;
  assign core_req.second_node = req_i.second_node;
  assign core_req.node_depth  = req_i.node_depth;
  assign core_req.is_root     = req_i.is_root;
  assign req_i.ready          = core_ready;

  tlca_core #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count_q),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (core_ready),
    .req_i        (core_req),
    .res_valid_o  (core_res_valid),
    .res_ready_i  (core_res_ready),
    .res_data_o   (core_res)
  );

  // output register frees the core as soon as the result is handed over
  assign core_res_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_res_ready) begin
      out_valid_q <= core_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res_valid && core_res_ready) begin
      out_data_q <= core_res;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.common_ancestor = out_data_q.common_ancestor;
  assign res_o.path_distance   = out_data_q.path_distance;

endmodule

>>> sv/tlca_chk.sv
// ----------------------------------------------------------------------------
// tlca_chk
// Port-level checks of the lca engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tree_lca_binary_lifting_assert.svh"

module tlca_chk import tlca_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic [MODE_W-1:0] req_mode_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [NODE_W-1:0] res_ca_i,
  input logic [DIST_W-1:0] res_pd_i
);

  // a pending result is never withdrawn
  `TLCA_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i, "result withdrawn before it was taken")

  // a pending result keeps its payload
  `TLCA_ASSERT_NOW(a_res_stable, clk_i, rst_ni, $past(res_valid_i && !res_ready_i), $stable(res_ca_i) && $stable(res_pd_i), "result payload changed while stalled")

  // a query request keeps the engine busy at least while it folds both indices
  `TLCA_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, req_valid_i && req_ready_i && req_mode_i == MODE_QUERY, !req_ready_i ##1 !req_ready_i, "engine ready too early after a query request")

  // an unused mode is dropped without occupying the engine
  `TLCA_ASSERT_NEXT(a_unused_mode, clk_i, rst_ni, req_valid_i && req_ready_i && req_mode_i != MODE_LOAD && req_mode_i != MODE_BUILD && req_mode_i != MODE_QUERY, req_ready_i, "unused mode request occupied the engine")

endmodule

bind tree_lca_binary_lifting tlca_chk u_tlca_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_mode_i  (req_i.mode),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_ca_i    (res_o.common_ancestor),
  .res_pd_i    (res_o.path_distance)
);
